// ----- hw/rtl/dwsl_pkg.sv -----
package dwsl_pkg;

  // Character codes the scanner reacts to
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HIGH  = 8'h80;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [3:0]  LEN_MAX   = 4'hF;

  // Item kinds
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PATTERN_TEXT   = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1
  } cfg_idx_e;

  // Line scan phase
  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_SCAN = 2'd1,
    PH_SKIP = 2'd2
  } phase_e;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic [15:0] lines_found;
    logic        line_match;
  } result_t;

endpackage

// ----- hw/rtl/dwsl_core.sv -----
module dwsl_core #(
  parameter int MAX_PATTERN = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  dwsl_pkg::item_t  item_i,
  input  logic [63:0]      pattern_text_i,
  input  logic [3:0]       pattern_length_i,
  output dwsl_pkg::result_t result_o
);

  dwsl_pkg::phase_e phase_q, phase_d;
  logic matched_q, matched_d;
  logic [1:0][7:0] win_q, win_d;
  logic [1:0] fill_q, fill_d;
  logic [MAX_PATTERN-1:0][7:0] tail_q, tail_d;
  logic [3:0] wlen_q, wlen_d;
  logic [MAX_PATTERN-1:0][7:0] blank_q, blank_d;
  logic [3:0] bcnt_q, bcnt_d;
  logic quote_q, quote_d;
  logic [15:0] total_q, total_d;

  logic [7:0] ch;
  logic [7:0] fb;
  logic first_ok, byte_active, is_delim, fb_blank;
  logic dbl_eq, tail_hit;
  logic [3:0] n_eff, len_eff;
  logic [4:0] wlen_sum;
  logic [MAX_PATTERN-1:0][7:0] merged;

  assign ch = item_i.ch;
  assign fb = win_q[0];
  assign fb_blank = (fb == dwsl_pkg::CH_SPACE) || (fb == dwsl_pkg::CH_TAB);

  // First byte of a line must be high or a Latin letter
  assign first_ok = (ch >= dwsl_pkg::CH_HIGH) ||
                    ((ch >= dwsl_pkg::CH_UP_A) && (ch <= dwsl_pkg::CH_UP_Z)) ||
                    ((ch >= dwsl_pkg::CH_LO_A) && (ch <= dwsl_pkg::CH_LO_Z));

  assign byte_active = fire_i && (item_i.op == dwsl_pkg::OP_CHAR) &&
                       ((phase_q == dwsl_pkg::PH_SCAN) ||
                        ((phase_q == dwsl_pkg::PH_WAIT) && first_ok));

  // " = " seen across the two held-back bytes and the new one
  assign is_delim = (fill_q == 2'd2) && (win_q[0] == dwsl_pkg::CH_SPACE) &&
                    (win_q[1] == dwsl_pkg::CH_EQUAL) && (ch == dwsl_pkg::CH_SPACE);

  // Pending blanks that still fit in the tail
  assign n_eff = (bcnt_q > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : bcnt_q;
  assign wlen_sum = 5'(wlen_q) + 5'(bcnt_q) + 5'd1;

  // Tail after flushing pending blanks and pushing the new byte
  always_comb begin
    merged = '0;
    merged[0] = fb;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      if (n_eff >= 4'(j)) begin
        merged[j] = blank_q[j-1];
      end
      for (int m = 0; m < j; m++) begin
        if (n_eff == 4'(m)) begin
          merged[j] = tail_q[j-1-m];
        end
      end
    end
  end

  // Suffix compare against the pattern
  always_comb begin
    if (pattern_length_i == 4'd0) begin
      len_eff = 4'd1;
    end else if (pattern_length_i > 4'(MAX_PATTERN)) begin
      len_eff = 4'(MAX_PATTERN);
    end else begin
      len_eff = pattern_length_i;
    end
    tail_hit = (wlen_q >= len_eff);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if ((4'(k) < len_eff) && (tail_q[k] != pattern_text_i[8*k +: 8])) begin
        tail_hit = 1'b0;
      end
    end
  end

  assign dbl_eq = (wlen_q == 4'd2) && (tail_q[0] == dwsl_pkg::CH_EQUAL) &&
                  (tail_q[1] == dwsl_pkg::CH_EQUAL);

  // Result of a line end, count included
  always_comb begin
    result_o.line_match  = matched_q;
    result_o.lines_found = (matched_q && (total_q != dwsl_pkg::COUNT_MAX)) ?
                           total_q + 16'd1 : total_q;
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (fire_i) begin
      if (item_i.op == dwsl_pkg::OP_EOL) begin
        phase_d = dwsl_pkg::PH_WAIT;
      end else if (phase_q == dwsl_pkg::PH_WAIT) begin
        phase_d = first_ok ? dwsl_pkg::PH_SCAN : dwsl_pkg::PH_SKIP;
      end
      if (byte_active && is_delim && (dbl_eq || quote_q)) begin
        phase_d = dwsl_pkg::PH_SKIP;
      end
    end
  end

  // Window, segment and count update
  always_comb begin
    matched_d = matched_q;
    win_d     = win_q;
    fill_d    = fill_q;
    tail_d    = tail_q;
    wlen_d    = wlen_q;
    blank_d   = blank_q;
    bcnt_d    = bcnt_q;
    quote_d   = quote_q;
    total_d   = total_q;
    if (fire_i && (item_i.op == dwsl_pkg::OP_EOL)) begin
      total_d   = result_o.lines_found;
      matched_d = 1'b0;
      win_d     = '0;
      fill_d    = 2'd0;
      tail_d    = '0;
      wlen_d    = 4'd0;
      blank_d   = '0;
      bcnt_d    = 4'd0;
      quote_d   = 1'b0;
    end else if (byte_active) begin
      if (is_delim) begin
        // segment closes
        fill_d = 2'd0;
        if (!(dbl_eq || quote_q) && (wlen_q != 4'd0) && tail_hit) begin
          matched_d = 1'b1;
        end
        tail_d  = '0;
        wlen_d  = 4'd0;
        blank_d = '0;
        bcnt_d  = 4'd0;
        quote_d = 1'b0;
      end else if (fill_q == 2'd2) begin
        // oldest held byte goes into the segment
        win_d[0] = win_q[1];
        win_d[1] = ch;
        if (fb == dwsl_pkg::CH_QUOTE) begin
          quote_d = 1'b1;
        end
        if (fb_blank) begin
          if (wlen_q != 4'd0) begin
            blank_d[0] = fb;
            for (int i = 1; i < MAX_PATTERN; i++) begin
              blank_d[i] = blank_q[i-1];
            end
            if (bcnt_q != dwsl_pkg::LEN_MAX) begin
              bcnt_d = bcnt_q + 4'd1;
            end
          end
        end else begin
          tail_d = merged;
          wlen_d = (wlen_sum > 5'(dwsl_pkg::LEN_MAX)) ? dwsl_pkg::LEN_MAX : wlen_sum[3:0];
          bcnt_d = 4'd0;
        end
      end else begin
        win_d[fill_q[0]] = ch;
        fill_d = fill_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= dwsl_pkg::PH_WAIT;
      matched_q <= 1'b0;
      win_q     <= '0;
      fill_q    <= 2'd0;
      tail_q    <= '0;
      wlen_q    <= 4'd0;
      blank_q   <= '0;
      bcnt_q    <= 4'd0;
      quote_q   <= 1'b0;
      total_q   <= 16'd0;
    end else begin
      phase_q   <= phase_d;
      matched_q <= matched_d;
      win_q     <= win_d;
      fill_q    <= fill_d;
      tail_q    <= tail_d;
      wlen_q    <= wlen_d;
      blank_q   <= blank_d;
      bcnt_q    <= bcnt_d;
      quote_q   <= quote_d;
      total_q   <= total_d;
    end
  end

endmodule

// ----- hw/rtl/delimited_word_suffix_line_filter_unit.sv -----
// Line suffix filter: text bytes stream in one per transfer (tuser = 0) and an
// end-of-line transfer (tuser = 1) closes the line and yields one result with the
// match flag and a saturating count of matching lines. Lines whose first byte is
// not 0x80 or above or a Latin letter never match. Each byte passes an input
// register and updates the line state, and a line result sits in an output
// register, so a new transfer is accepted every cycle unless a line result is
// held back by the downstream side. Character transfers produce no output.
// Write the pattern registers only while the block is idle.
module delimited_word_suffix_line_filter_unit #(
  parameter int MAX_PATTERN = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] op (1 = end of line)
  // line results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] line_match, [16:1] lines_found, zero fill
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic in_valid_q, in_valid_d;
  dwsl_pkg::item_t in_item_q;
  logic out_valid_q, out_valid_d;
  dwsl_pkg::result_t out_res_q;
  dwsl_pkg::result_t core_res;
  logic [63:0] pat_text_q;
  logic [3:0]  pat_len_q;
  logic advance, out_load, s_fire;

  // Input stage moves on unless a line result has nowhere to go
  assign advance  = in_valid_q && ((in_item_q.op == dwsl_pkg::OP_CHAR) ||
                                   !out_valid_q || m_axis_tready);
  assign out_load = advance && (in_item_q.op == dwsl_pkg::OP_EOL);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_fire || (in_valid_q && !advance);
  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_item_q.op <= s_axis_tuser;
      in_item_q.ch <= s_axis_tdata;
    end
    if (out_load) begin
      out_res_q <= core_res;
    end
  end

  // Pattern registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_text_q <= 64'd0;
      pat_len_q  <= 4'd1;
    end else if (cfg_valid_i) begin
      case (dwsl_pkg::cfg_idx_e'(cfg_index_i))
        dwsl_pkg::CFG_PATTERN_TEXT:   pat_text_q <= cfg_data_i;
        dwsl_pkg::CFG_PATTERN_LENGTH: pat_len_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  dwsl_core #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (advance),
    .item_i          (in_item_q),
    .pattern_text_i  (pat_text_q),
    .pattern_length_i(pat_len_q),
    .result_o        (core_res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_res_q.lines_found, out_res_q.line_match};

endmodule

// ----- hw/rtl/dwsl_checker.sv -----
module dwsl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  logic        seen_q;
  logic [15:0] prev_found_q;
  logic        out_xfer;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Count carried by the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      prev_found_q <= 16'd0;
    end else if (out_xfer) begin
      seen_q       <= 1'b1;
      prev_found_q <= m_axis_tdata[16:1];
    end
  end

  // A held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Input only stalls behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // A matching line is always counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[16:1] != 16'd0)
    else $error("match reported with zero count");

  // Count steps by one per match until it saturates and holds otherwise
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && seen_q && !m_axis_tdata[0] |-> m_axis_tdata[16:1] == prev_found_q)
    else $error("count moved on a non-matching line");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && seen_q && m_axis_tdata[0] && prev_found_q != dwsl_pkg::COUNT_MAX
    |-> m_axis_tdata[16:1] == prev_found_q + 16'd1)
    else $error("count did not advance on a matching line");

endmodule

bind delimited_word_suffix_line_filter_unit dwsl_checker u_dwsl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
